// ===== hdl/arct_pkg.sv =====
// shared types, constants and codes for the address range coalescing table
`timescale 1ns / 1ps
`default_nettype none

package arct_pkg;

    // table geometry and field widths
    localparam int DEPTH_DEFAULT = 64;
    localparam int BASE_W        = 32;
    localparam int SIZE_W        = 32;
    localparam int LEN_W         = 33;
    localparam int END_W         = 34;
    localparam int CNT_W         = 7;
    localparam int IDX_IN_W      = 6;
    localparam int STATUS_W      = 2;

    // transaction kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_READ     = 2'd2
    } status_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } arct_state_t;

    // probe travelling down the chain of cells, one cell per cycle
    typedef struct packed {
        logic              op;          // insert or read
        logic [BASE_W-1:0] lo;          // merged base, or base of the entry read
        logic [END_W-1:0]  hi;          // merged exclusive end, or length read
        logic              changed;     // an entry was absorbed on this pass
        logic [CNT_W-1:0]  count;       // absorbed entries, saturating
        logic              free_found;  // a free slot has been claimed on this pass
        logic              rd_valid;    // valid bit of the entry read
    } probe_t;

    // data written into the claimed slot
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/arct_cell.sv =====
// one table slot: holds an entry and processes the passing probe
`timescale 1ns / 1ps
`default_nettype none

module arct_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_act,
    input  wire arct_pkg::probe_t              probe_in,
    input  wire logic [arct_pkg::IDX_IN_W-1:0] rd_index,
    input  wire logic                          wr_en,
    input  wire arct_pkg::entry_t              wr_data,
    output logic                               out_act,
    output arct_pkg::probe_t                   probe_out
);
    import arct_pkg::*;

    logic              valid_reg;
    logic              claim_reg;
    logic [BASE_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              act_reg;
    probe_t            probe_reg;
    probe_t            probe_next;

    logic [END_W-1:0]  elo;
    logic [END_W-1:0]  ehi;
    logic              is_ins;
    logic              overlap;
    logic              take_free;
    logic              hit;

    // overlap test, free slot claim and read match
    always_comb
    begin
        elo       = {{(END_W-BASE_W){1'b0}}, base_reg};
        ehi       = elo + {{(END_W-LEN_W){1'b0}}, len_reg};
        is_ins    = in_act && (probe_in.op == KIND_INSERT);
        overlap   = is_ins && valid_reg && (elo < probe_in.hi)
                    && ({{(END_W-BASE_W){1'b0}}, probe_in.lo} < ehi);
        take_free = is_ins && !valid_reg && !probe_in.free_found;
        hit       = in_act && (probe_in.op == KIND_READ)
                    && (INDEX < (2 ** IDX_IN_W)) && (int'(rd_index) == INDEX);

        probe_next = probe_in;
        if (overlap)
        begin
            if (base_reg < probe_in.lo)
            begin
                probe_next.lo = base_reg;
            end
            if (ehi > probe_in.hi)
            begin
                probe_next.hi = ehi;
            end
            probe_next.changed = 1'b1;
            if (probe_in.count != '1)
            begin
                probe_next.count = probe_in.count + 1'b1;
            end
        end
        if (take_free)
        begin
            probe_next.free_found = 1'b1;
        end
        if (hit)
        begin
            probe_next.lo       = base_reg;
            probe_next.hi       = {{(END_W-LEN_W){1'b0}}, len_reg};
            probe_next.rd_valid = valid_reg;
        end
    end

    // control state of the slot and probe handoff
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            act_reg   <= 1'b0;
        end
        else
        begin
            act_reg <= in_act;
            if (wr_en && claim_reg)
            begin
                valid_reg <= 1'b1;
            end
            else if (overlap)
            begin
                valid_reg <= 1'b0;
            end
            if (is_ins)
            begin
                claim_reg <= take_free;
            end
        end
    end

    // entry payload and probe payload
    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        if (wr_en && claim_reg)
        begin
            base_reg <= wr_data.base;
            len_reg  <= wr_data.len;
        end
    end

    assign out_act   = act_reg;
    assign probe_out = probe_reg;

endmodule

`default_nettype wire

// ===== hdl/address_range_coalescing_table_core.sv =====
// top level: pass controller and the chain of table cells
//
// channel   direction  handshake             payload
// command   in         start && !busy        kind, region_base, region_size, entry_index
// result    out        done (one cycle)      status, out_base, out_size, absorbed_count,
//                                            out_valid
//
// a read walks the chain of cells once from accept to done
// an insert walks the chain once per pass; passes repeat until one absorbs nothing,
//   so the number of passes is at least 1 and at most TABLE_DEPTH + 1
// an insert of zero size answers in the cycle after its accept, without a pass
// after reset every slot is empty; the block is ready at once
// results are never held: done lasts one cycle and the receiver must take it
`timescale 1ns / 1ps
`default_nettype none

module address_range_coalescing_table_core #(
    parameter int TABLE_DEPTH = arct_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          kind,
    input  wire logic [arct_pkg::BASE_W-1:0]   region_base,
    input  wire logic [arct_pkg::SIZE_W-1:0]   region_size,
    input  wire logic [arct_pkg::IDX_IN_W-1:0] entry_index,
    output logic                               done,
    output logic [arct_pkg::STATUS_W-1:0]      status,
    output logic [arct_pkg::BASE_W-1:0]        out_base,
    output logic [arct_pkg::LEN_W-1:0]         out_size,
    output logic [arct_pkg::CNT_W-1:0]         absorbed_count,
    output logic                               out_valid
);
    import arct_pkg::*;

    arct_state_t         state_reg, state_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [IDX_IN_W-1:0] idx_reg, idx_next;
    logic                head_act_reg, head_act_next;
    probe_t              head_reg, head_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [BASE_W-1:0]   out_base_reg, out_base_next;
    logic [LEN_W-1:0]    out_size_reg, out_size_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                wr_en_reg, wr_en_next;
    entry_t              wr_data_reg, wr_data_next;

    logic [TABLE_DEPTH:0] act;
    probe_t               probe [TABLE_DEPTH+1];
    logic                 tail_act;
    probe_t               tail;
    logic [END_W-1:0]     merged_len;

    assign act[0]   = head_act_reg;
    assign probe[0] = head_reg;
    assign tail_act = act[TABLE_DEPTH];
    assign tail     = probe[TABLE_DEPTH];

    // chain of slots
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        arct_cell #(
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_act    (act[g]),
            .probe_in  (probe[g]),
            .rd_index  (idx_reg),
            .wr_en     (wr_en_reg),
            .wr_data   (wr_data_reg),
            .out_act   (act[g+1]),
            .probe_out (probe[g+1])
        );
    end

    // next state, pass launch and result
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        head_act_next  = 1'b0;
        head_next      = head_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_base_next  = out_base_reg;
        out_size_next  = out_size_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        wr_en_next     = 1'b0;
        wr_data_next   = wr_data_reg;
        merged_len     = tail.hi - {{(END_W-BASE_W){1'b0}}, tail.lo};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    base_next = region_base;
                    size_next = region_size;
                    idx_next  = entry_index;
                    head_next = '0;
                    if (kind == KIND_READ)
                    begin
                        head_next.op  = KIND_READ;
                        head_act_next = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else if (region_size == '0)
                    begin
                        // zero size holds no byte: answer at once
                        done_next      = 1'b1;
                        status_next    = STATUS_INSERTED;
                        out_base_next  = region_base;
                        out_size_next  = '0;
                        count_next     = '0;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        head_next.op  = KIND_INSERT;
                        head_next.lo  = region_base;
                        head_next.hi  = {{(END_W-BASE_W){1'b0}}, region_base}
                                        + {{(END_W-SIZE_W){1'b0}}, region_size};
                        head_act_next = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tail_act)
                begin
                    if (tail.op == KIND_READ)
                    begin
                        done_next      = 1'b1;
                        status_next    = STATUS_READ;
                        out_base_next  = tail.lo;
                        out_size_next  = tail.hi[LEN_W-1:0];
                        count_next     = '0;
                        out_valid_next = tail.rd_valid;
                        state_next     = ST_IDLE;
                    end
                    else if (tail.changed)
                    begin
                        // range grew: another pass
                        head_next            = tail;
                        head_next.changed    = 1'b0;
                        head_next.free_found = 1'b0;
                        head_act_next        = 1'b1;
                    end
                    else if (tail.free_found)
                    begin
                        wr_en_next        = 1'b1;
                        wr_data_next.base = tail.lo;
                        wr_data_next.len  = merged_len[LEN_W-1:0];
                        done_next         = 1'b1;
                        status_next       = STATUS_INSERTED;
                        out_base_next     = tail.lo;
                        out_size_next     = merged_len[LEN_W-1:0];
                        count_next        = tail.count;
                        out_valid_next    = 1'b0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        // no free slot: range dropped as brought
                        done_next      = 1'b1;
                        status_next    = STATUS_FULL;
                        out_base_next  = base_reg;
                        out_size_next  = {{(LEN_W-SIZE_W){1'b0}}, size_reg};
                        count_next     = '0;
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_act_reg <= 1'b0;
            done_reg     <= 1'b0;
            wr_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_act_reg <= head_act_next;
            done_reg     <= done_next;
            wr_en_reg    <= wr_en_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        size_reg      <= size_next;
        idx_reg       <= idx_next;
        head_reg      <= head_next;
        status_reg    <= status_next;
        out_base_reg  <= out_base_next;
        out_size_reg  <= out_size_next;
        count_reg     <= count_next;
        out_valid_reg <= out_valid_next;
        wr_data_reg   <= wr_data_next;
    end

    assign busy           = (state_reg == ST_SCAN);
    assign done           = done_reg;
    assign status         = status_reg;
    assign out_base       = out_base_reg;
    assign out_size       = out_size_reg;
    assign absorbed_count = count_reg;
    assign out_valid      = out_valid_reg;

    // at most one probe in the chain
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act))
        else $error("more than one probe in the chain");

    // probes only travel while a transaction is in progress
    a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (act != '0) |-> busy)
        else $error("probe in the chain while idle");

    // a slot write always comes with an insert result
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> (done && (status == STATUS_INSERTED)))
        else $error("slot write without insert result");

    // a result never comes while a scan is in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while scan in progress");

    // a launched pass reaches the tail after passing through every cell
    a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        head_act_reg |-> ##(TABLE_DEPTH) tail_act)
        else $error("probe lost in the chain");

endmodule

`default_nettype wire

// ===== tb/arct_table_checker.sv =====
// checker for the range table: mirrors the table, predicts each reply and compares results
`timescale 1ns / 1ps

module arct_table_checker #(
    parameter int TABLE_DEPTH = arct_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          kind,
    input  logic [arct_pkg::BASE_W-1:0]   region_base,
    input  logic [arct_pkg::SIZE_W-1:0]   region_size,
    input  logic [arct_pkg::IDX_IN_W-1:0] entry_index,
    input  logic                          done,
    input  logic [arct_pkg::STATUS_W-1:0] status,
    input  logic [arct_pkg::BASE_W-1:0]   out_base,
    input  logic [arct_pkg::LEN_W-1:0]    out_size,
    input  logic [arct_pkg::CNT_W-1:0]    absorbed_count,
    input  logic                          out_valid,
    output int                            mismatch_count,
    output int                            replies_pending,
    output int                            slots_written
);

    // one predicted result transaction
    typedef struct packed {
        arct_pkg::status_t              st;
        logic [arct_pkg::BASE_W-1:0]    base;
        logic [arct_pkg::LEN_W-1:0]     size;
        logic [arct_pkg::CNT_W-1:0]     cnt;
        logic                           valid;
    } table_reply_t;

    // mirror of the range table
    logic [arct_pkg::BASE_W-1:0] mirror_base [TABLE_DEPTH];
    logic [arct_pkg::LEN_W-1:0]  mirror_len  [TABLE_DEPTH];
    bit                          mirror_live [TABLE_DEPTH];

    table_reply_t awaited_replies [$];
    table_reply_t oldest_reply;
    int           written_hwm   = 0;
    int           fail_tally    = 0;
    int           pending_view  = 0;
    int           written_view  = 0;

    assign mismatch_count  = fail_tally;
    assign replies_pending = pending_view;
    assign slots_written   = written_view;

    // insert with repeated merge passes, or read of one slot
    function automatic table_reply_t coalesce_or_read(
        input logic                          cmd_kind,
        input logic [arct_pkg::BASE_W-1:0]   cmd_base,
        input logic [arct_pkg::SIZE_W-1:0]   cmd_size,
        input logic [arct_pkg::IDX_IN_W-1:0] cmd_index
    );
        table_reply_t                reply;
        logic [arct_pkg::END_W-1:0]  lo;
        logic [arct_pkg::END_W-1:0]  hi;
        logic [arct_pkg::END_W-1:0]  elo;
        logic [arct_pkg::END_W-1:0]  ehi;
        logic [arct_pkg::END_W-1:0]  span;
        int                          absorbed;
        bit                          changed;
        int                          slot;
        int                          i;
        reply = '0;
        if (cmd_kind == arct_pkg::KIND_READ)
        begin
            reply.st = arct_pkg::STATUS_READ;
            if (int'(cmd_index) < TABLE_DEPTH)
            begin
                reply.base  = mirror_base[cmd_index];
                reply.size  = mirror_len[cmd_index];
                reply.valid = mirror_live[cmd_index];
            end
            return reply;
        end
        reply.st   = arct_pkg::STATUS_INSERTED;
        reply.base = cmd_base;
        // an empty range holds no byte: nothing merged, nothing stored
        if (cmd_size == '0)
            return reply;
        // widen over overlapping entries until a pass absorbs nothing
        lo       = {2'b00, cmd_base};
        hi       = {2'b00, cmd_base} + {2'b00, cmd_size};
        absorbed = 0;
        changed  = 1'b1;
        while (changed)
        begin
            changed = 1'b0;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                if (mirror_live[i])
                begin
                    elo = {2'b00, mirror_base[i]};
                    ehi = elo + {1'b0, mirror_len[i]};
                    if (elo < hi && lo < ehi)
                    begin
                        if (elo < lo)
                            lo = elo;
                        if (ehi > hi)
                            hi = ehi;
                        mirror_live[i] = 1'b0;
                        absorbed++;
                        changed = 1'b1;
                    end
                end
            end
        end
        // lowest free slot takes the merged range
        slot = -1;
        for (i = 0; i < TABLE_DEPTH && slot < 0; i++)
        begin
            if (!mirror_live[i])
                slot = i;
        end
        if (slot < 0)
        begin
            reply.st   = arct_pkg::STATUS_FULL;
            reply.size = {1'b0, cmd_size};
            return reply;
        end
        span              = hi - lo;
        mirror_base[slot] = lo[arct_pkg::BASE_W-1:0];
        mirror_len[slot]  = span[arct_pkg::LEN_W-1:0];
        mirror_live[slot] = 1'b1;
        if (slot >= written_hwm)
            written_hwm = slot + 1;
        reply.base = lo[arct_pkg::BASE_W-1:0];
        reply.size = span[arct_pkg::LEN_W-1:0];
        reply.cnt  = (absorbed > 127) ? 7'd127 : arct_pkg::CNT_W'(absorbed);
        return reply;
    endfunction

    task automatic check_field(
        input string                      field_name,
        input logic [arct_pkg::LEN_W-1:0] want,
        input logic [arct_pkg::LEN_W-1:0] got
    );
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field_name, want, got);
            fail_tally++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            mirror_live[i] = 1'b0;
    end

    // result transactions first, then the command accepted at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("result transaction with no command pending: status %0d base %0h",
                           status, out_base);
                    fail_tally++;
                end
                else
                begin
                    oldest_reply = awaited_replies.pop_front();
                    check_field("status", arct_pkg::LEN_W'(oldest_reply.st),
                                arct_pkg::LEN_W'(status));
                    check_field("out_base", arct_pkg::LEN_W'(oldest_reply.base),
                                arct_pkg::LEN_W'(out_base));
                    check_field("out_size", oldest_reply.size, out_size);
                    check_field("absorbed_count", arct_pkg::LEN_W'(oldest_reply.cnt),
                                arct_pkg::LEN_W'(absorbed_count));
                    check_field("out_valid", arct_pkg::LEN_W'(oldest_reply.valid),
                                arct_pkg::LEN_W'(out_valid));
                end
            end
            if (start && !busy)
                awaited_replies.push_back(
                    coalesce_or_read(kind, region_base, region_size, entry_index));
            pending_view <= awaited_replies.size();
            written_view <= written_hwm;
        end
    end

endmodule

// ===== tb/tb_address_range_coalescing_table_core.sv =====
// testbench top: clock, reset, command stimulus and verdict for the coalescing table
`timescale 1ns / 1ps

module tb_address_range_coalescing_table_core;

    localparam int TABLE_DEPTH   = arct_pkg::DEPTH_DEFAULT;
    localparam int HALF_PERIOD   = 4;
    localparam int PHASE_ITEMS   = 560;
    localparam int CLUSTER_SPAN  = 4096;
    localparam int MAX_GAP       = 64;
    // worst insert: one pass per absorbed entry plus the final empty pass
    localparam int WORST_ITEM    = (TABLE_DEPTH + 1) * (TABLE_DEPTH + 1) + 2 * MAX_GAP + 2;
    localparam int CYCLE_LIMIT   = 2 * 1800 * WORST_ITEM;
    localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 1);

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          kind;
    logic [arct_pkg::BASE_W-1:0]   region_base;
    logic [arct_pkg::SIZE_W-1:0]   region_size;
    logic [arct_pkg::IDX_IN_W-1:0] entry_index;
    logic                          done;
    logic [arct_pkg::STATUS_W-1:0] status;
    logic [arct_pkg::BASE_W-1:0]   out_base;
    logic [arct_pkg::LEN_W-1:0]    out_size;
    logic [arct_pkg::CNT_W-1:0]    absorbed_count;
    logic                          out_valid;

    int                            mismatch_count;
    int                            replies_pending;
    int                            slots_written;
    int                            sender_idle_pct = 0;
    logic [arct_pkg::BASE_W-1:0]   cluster_base    = '0;
    int                            cycle_count     = 0;

    address_range_coalescing_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .region_base    (region_base),
        .region_size    (region_size),
        .entry_index    (entry_index),
        .done           (done),
        .status         (status),
        .out_base       (out_base),
        .out_size       (out_size),
        .absorbed_count (absorbed_count),
        .out_valid      (out_valid)
    );

    arct_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .region_base     (region_base),
        .region_size     (region_size),
        .entry_index     (entry_index),
        .done            (done),
        .status          (status),
        .out_base        (out_base),
        .out_size        (out_size),
        .absorbed_count  (absorbed_count),
        .out_valid       (out_valid),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending),
        .slots_written   (slots_written)
    );

    // clock
    initial
        clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one command transaction, after an optional idle gap
    task automatic issue_command(
        input logic                          cmd_kind,
        input logic [arct_pkg::BASE_W-1:0]   cmd_base,
        input logic [arct_pkg::SIZE_W-1:0]   cmd_size,
        input logic [arct_pkg::IDX_IN_W-1:0] cmd_index
    );
        int gap;
        gap = 0;
        while (sender_idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap != 0)
        begin
            start <= 1'b0;
            // sometimes let the gap start only once the block is free
            if ($urandom_range(0, 1) == 1)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= cmd_kind;
        region_base <= cmd_base;
        region_size <= cmd_size;
        entry_index <= cmd_index;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every result transaction has come back
    task automatic settle_table();
        start <= 1'b0;
        @(posedge clk);
        while (replies_pending != 0)
            @(posedge clk);
    endtask

    // mostly clustered inserts and reads, some sweeps and wide noise
    task automatic send_random_transaction();
        int                          pick;
        logic [arct_pkg::SIZE_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 25 && slots_written > 0)
            issue_command(arct_pkg::KIND_READ, $urandom, $urandom,
                          arct_pkg::IDX_IN_W'($urandom_range(0, slots_written - 1)));
        else if (pick < 30)
            // wide ranges kept in the upper half so the lower half stays fragmented
            issue_command(arct_pkg::KIND_INSERT, 32'h8000_0000 | $urandom, $urandom,
                          arct_pkg::IDX_IN_W'($urandom));
        else if (pick < 33)
            issue_command(arct_pkg::KIND_INSERT, $urandom, '0,
                          arct_pkg::IDX_IN_W'($urandom));
        else if (pick < 34)
            // swallow the whole lower half
            issue_command(arct_pkg::KIND_INSERT, '0, 32'h8000_0000,
                          arct_pkg::IDX_IN_W'($urandom));
        else if (pick < 38)
            issue_command(arct_pkg::KIND_INSERT, cluster_base + $urandom_range(0, 1023),
                          $urandom_range(1024, CLUSTER_SPAN), arct_pkg::IDX_IN_W'($urandom));
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 64);
            issue_command(arct_pkg::KIND_INSERT,
                          cluster_base + $urandom_range(0, CLUSTER_SPAN - 1), len,
                          arct_pkg::IDX_IN_W'($urandom));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int k;
        int phase;
        int phase_pct;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = arct_pkg::KIND_INSERT;
        region_base = '0;
        region_size = '0;
        entry_index = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty range
        issue_command(arct_pkg::KIND_INSERT, 32'hFFFF_FFFF, '0, '0);
        // fill every slot, odd slots touching their upper neighbour
        for (k = 0; k < TABLE_DEPTH; k++)
            issue_command(arct_pkg::KIND_INSERT, 32'(k * 16),
                          (k % 2 == 1) ? 32'd16 : 32'($urandom_range(1, 16)), '0);
        // no free slot and no overlap: dropped
        issue_command(arct_pkg::KIND_INSERT, 32'h0000_2000, 32'd1, '0);
        settle_table();
        issue_command(arct_pkg::KIND_READ, '0, '0, '0);
        issue_command(arct_pkg::KIND_READ, '0, '0, 6'h3F);
        // starts on the last byte of slot 1
        issue_command(arct_pkg::KIND_INSERT, 32'd31, 32'd1, '0);
        // covers every entry at once
        issue_command(arct_pkg::KIND_INSERT, '0, 32'h0000_0400, '0);
        // invalidated slots keep their last contents
        issue_command(arct_pkg::KIND_READ, '0, '0, 6'd5);
        issue_command(arct_pkg::KIND_READ, '0, '0, 6'd1);
        // largest sizes; the merge gives a length above 32 bits
        issue_command(arct_pkg::KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, '0);
        issue_command(arct_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        issue_command(arct_pkg::KIND_READ, '0, '0, 6'd1);
        issue_command(arct_pkg::KIND_INSERT, '0, '0, 6'h3F);
        issue_command(arct_pkg::KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd2);
        settle_table();

        // random phases: no idling, heavy sender idling, light sender idling
        for (phase = 0; phase < 3; phase++)
        begin
            phase_pct = (phase == 0) ? 0 : ((phase == 1) ? 76 : 28);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 40 == 0)
                    sender_idle_pct = ($urandom_range(0, 4) == 0) ? 0 : phase_pct;
                if (k % 60 == 0)
                    cluster_base = $urandom_range(0, 32'h7FFF_E000);
                send_random_transaction();
            end
            settle_table();
        end

        // drain and verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
